FILE: src/bounded_set_table_defines.svh
// Assertion macros shared by the bounded set table RTL.
// No dependencies; included inside module bodies.
`ifndef BOUNDED_SET_TABLE_DEFINES_SVH
`define BOUNDED_SET_TABLE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BST_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bounded_set_table: check failed");

// Next-cycle implication, checked out of reset.
`define BST_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bounded_set_table: check failed");

`endif

FILE: src/bst_pkg.sv
// Types, sizes and codes for the bounded set table.
// No dependencies; imported by bst_mem, bounded_set_table, bst_checker and the testbench.
package bst_pkg;

    localparam int CAPACITY  = 16;
    localparam int KEY_WIDTH = 32;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMD_W   = 2;
    localparam int KEYIN_W = 32;
    localparam int STAT_W  = 3;
    localparam int CFG_W   = 5;
    localparam int OCNT_W  = 5;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd1;
    localparam logic [STAT_W-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd4;

    localparam logic [CFG_W-1:0] CFG_LIMIT_RESET = 5'd16;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [CNT_W-1:0]     t_cnt;

    typedef struct packed {
        logic en;
        t_idx addr;
        t_key data;
    } t_mem_wr;

endpackage

FILE: src/bst_mem.sv
// Entry store for the bounded set table: one write port, one registered read.
// Depends on bst_pkg.
module bst_mem (
    input  logic              i_clk,
    input  bst_pkg::t_mem_wr  i_wr,
    input  bst_pkg::t_idx     i_rd_addr,
    output bst_pkg::t_key     o_rd_data
);
    import bst_pkg::*;

    t_key r_mem [CAPACITY];
    t_key r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/bounded_set_table.sv
// Bounded set table: insertion-ordered set of distinct keys with add/remove/lookup.
// The search reads one entry a cycle, then a remove compacts the entries behind the hit one
// a cycle. One transaction at a time: ready returns with the result, and a result still
// waiting on the output stalls the finish.
// Reset (synchronous, active low): count 0, limit 16, output empty; entries untouched.
module bounded_set_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bst_pkg::CMD_W-1:0]   i_command,
    input  logic [bst_pkg::KEYIN_W-1:0] i_key,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bst_pkg::STAT_W-1:0]  o_status,
    output logic                        o_found,
    output logic [bst_pkg::OCNT_W-1:0]  o_entry_count,
    output logic                        o_is_full_flag,
    output logic                        o_is_empty_flag,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [bst_pkg::CFG_W-1:0]   i_cfg_capacity_limit
);
    import bst_pkg::*;
    `include "bounded_set_table_defines.svh"

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SHIFT  = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam t_cnt CAP_CNT = t_cnt'(CAPACITY);

    logic [2:0]        r_state, n_state;
    t_cnt              r_count, n_count;
    logic [CFG_W-1:0]  r_cap_limit;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    t_key              r_key, n_key;
    t_cnt              r_idx, n_idx;
    logic              r_found, n_found;
    logic [STAT_W-1:0] r_stat, n_stat;

    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic              r_out_found;
    t_cnt              r_out_count;
    logic              r_out_full;
    logic              r_out_empty;

    t_mem_wr           mem_wr;
    t_idx              rd_addr;
    t_key              rd_data;
    t_cnt              lim;
    logic              at_limit;
    logic              out_free;
    logic [CNT_W:0]    idx_plus2;

    bst_mem u_mem (
        .i_clk     (i_clk),
        .i_wr      (mem_wr),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // limit of 0 behaves as 1, above capacity behaves as capacity
    always_comb begin
        if (r_cap_limit == '0) begin
            lim = t_cnt'(1);
        end else if ({1'b0, r_cap_limit} > (CFG_W + 1)'(CAPACITY)) begin
            lim = CAP_CNT;
        end else begin
            lim = t_cnt'(r_cap_limit);
        end
    end

    assign at_limit  = (r_count >= lim);
    assign out_free  = !r_out_valid || i_out_ready;
    assign idx_plus2 = {1'b0, r_idx} + (CNT_W + 1)'(2);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cmd   = r_cmd;
        n_key   = r_key;
        n_idx   = r_idx;
        n_found = r_found;
        n_stat  = r_stat;
        mem_wr  = '{en: 1'b0, addr: r_idx[IDX_W-1:0], data: rd_data};
        rd_addr = '0;

        unique case (r_state)
            S_IDLE: begin
                rd_addr = '0;
                if (i_in_valid) begin
                    n_cmd   = i_command;
                    n_key   = i_key[KEY_WIDTH-1:0];
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_state = S_SEARCH;
                end
            end
            // rd_data holds entry r_idx here
            S_SEARCH: begin
                rd_addr = r_idx[IDX_W-1:0] + t_idx'(1);
                if (r_idx >= r_count) begin
                    n_state = S_EXEC;
                end else if (rd_data == r_key) begin
                    n_found = 1'b1;
                    n_state = S_EXEC;
                end else begin
                    n_idx = r_idx + t_cnt'(1);
                end
            end
            S_EXEC: begin
                rd_addr = r_idx[IDX_W-1:0] + t_idx'(1);
                n_stat  = STAT_OK;
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_ADD: begin
                        if (at_limit) begin
                            n_stat = STAT_FULL;
                        end else if (r_found) begin
                            n_stat = STAT_DUPLICATE;
                        end else begin
                            mem_wr  = '{en: 1'b1, addr: r_count[IDX_W-1:0], data: r_key};
                            n_count = r_count + t_cnt'(1);
                        end
                    end
                    CMD_REMOVE: begin
                        if (r_count == '0) begin
                            n_stat = STAT_EMPTY;
                        end else if (!r_found) begin
                            n_stat = STAT_NOT_FOUND;
                        end else if ((r_idx + t_cnt'(1)) < r_count) begin
                            n_state = S_SHIFT;
                        end else begin
                            n_count = r_count - t_cnt'(1);
                        end
                    end
                    default: begin
                        // lookup, and the unused code behaves the same
                        n_stat = STAT_OK;
                    end
                endcase
            end
            // rd_data holds entry r_idx+1; move it down one place
            S_SHIFT: begin
                rd_addr = idx_plus2[IDX_W-1:0];
                mem_wr  = '{en: 1'b1, addr: r_idx[IDX_W-1:0], data: rd_data};
                n_idx   = r_idx + t_cnt'(1);
                if (idx_plus2 >= {1'b0, r_count}) begin
                    n_count = r_count - t_cnt'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                rd_addr = '0;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap_limit <= CFG_LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap_limit <= i_cfg_capacity_limit;
            end
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_key   <= n_key;
        r_idx   <= n_idx;
        r_found <= n_found;
        r_stat  <= n_stat;
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_stat;
            r_out_found  <= r_found;
            r_out_count  <= r_count;
            r_out_full   <= at_limit;
            r_out_empty  <= (r_count == '0);
        end
    end

    // limit changes only between transactions
    assign o_in_ready      = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_found         = r_out_found;
    assign o_entry_count   = OCNT_W'(r_out_count);
    assign o_is_full_flag  = r_out_full;
    assign o_is_empty_flag = r_out_empty;

    `BST_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CAP_CNT)
    `BST_ASSERT_IMP(a_shift_in_range, i_clk, i_rst_n, r_state == S_SHIFT, (r_idx + t_cnt'(1)) < r_count)
    `BST_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SEARCH)
    `BST_ASSERT_IMP(a_full_status_flag, i_clk, i_rst_n, o_out_valid && o_status == STAT_FULL, o_is_full_flag)

endmodule

FILE: verif/bst_checker.sv
// Checker for the bounded set table: watches the command, result and limit channels.
// Keeps its own copy of the key set, predicts each result and compares field by field.
// Depends on bst_pkg.
module bst_checker
    import bst_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [KEYIN_W-1:0] i_key,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [STAT_W-1:0]  i_status,
    input  logic               i_found,
    input  logic [OCNT_W-1:0]  i_entry_count,
    input  logic               i_is_full_flag,
    input  logic               i_is_empty_flag,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CFG_W-1:0]   i_cfg_capacity_limit,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct {
        logic [STAT_W-1:0] status;
        logic              found;
        logic [OCNT_W-1:0] entry_count;
        logic              full;
        logic              empty;
    } t_set_result;

    t_key              held_keys [CAPACITY];
    int unsigned       held_count = 0;
    logic [CFG_W-1:0]  limit_reg  = CFG_LIMIT_RESET;
    t_set_result       pending_results [$];
    t_set_result       want;
    int                fail_count = 0;
    int                pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic log_mismatch(string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // limit of 0 behaves as 1, anything above the table size as the table size
    function automatic int unsigned capacity_in_force();
        if (limit_reg == '0)
            return 1;
        if (limit_reg > CAPACITY)
            return CAPACITY;
        return 32'(limit_reg);
    endfunction

    function automatic t_set_result apply_set_command(logic [CMD_W-1:0] cmd, t_key key);
        t_set_result r;
        int unsigned lim;
        int unsigned pos;
        int          i;
        logic        present;

        lim = capacity_in_force();
        pos = held_count;
        for (i = 0; i < held_count; i++) begin
            if (held_keys[i] == key && pos == held_count)
                pos = i;
        end
        present  = (pos < held_count);
        r.status = STAT_OK;

        case (cmd)
            CMD_ADD: begin
                if (held_count >= lim)
                    r.status = STAT_FULL;
                else if (present)
                    r.status = STAT_DUPLICATE;
                else begin
                    held_keys[held_count] = key;
                    held_count++;
                end
            end
            CMD_REMOVE: begin
                if (held_count == 0)
                    r.status = STAT_EMPTY;
                else if (!present)
                    r.status = STAT_NOT_FOUND;
                else begin
                    // close the gap so the keys stay packed from slot 0
                    for (i = pos; i + 1 < held_count; i++)
                        held_keys[i] = held_keys[i + 1];
                    held_count--;
                end
            end
            default: ; // lookup, and the unused code acts as one
        endcase

        r.found       = present;
        r.entry_count = OCNT_W'(held_count);
        r.full        = (held_count >= lim);
        r.empty       = (held_count == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_count = 0;
            limit_reg  = CFG_LIMIT_RESET;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    log_mismatch($sformatf("result with no command pending (status %0d)",
                                           i_status));
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status)
                        log_mismatch($sformatf("status got %0d, expected %0d",
                                               i_status, want.status));
                    if (i_found !== want.found)
                        log_mismatch($sformatf("found got %0b, expected %0b",
                                               i_found, want.found));
                    if (i_entry_count !== want.entry_count)
                        log_mismatch($sformatf("entry_count got %0d, expected %0d",
                                               i_entry_count, want.entry_count));
                    if (i_is_full_flag !== want.full)
                        log_mismatch($sformatf("is_full_flag got %0b, expected %0b",
                                               i_is_full_flag, want.full));
                    if (i_is_empty_flag !== want.empty)
                        log_mismatch($sformatf("is_empty_flag got %0b, expected %0b",
                                               i_is_empty_flag, want.empty));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                limit_reg = i_cfg_capacity_limit;
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_set_command(i_command, i_key));
        end
        pending_count = pending_results.size();
    end

endmodule

FILE: verif/bounded_set_table_tb.sv
// Top of the bounded set table testbench: clock, reset, command and limit stimulus, verdict.
// Depends on bst_pkg, bounded_set_table and bst_checker.
module bounded_set_table_tb;
    import bst_pkg::*;

    localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 450;
    localparam int DRAIN_CYCLES = 40;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [CMD_W-1:0]   command    = CMD_LOOKUP;
    logic [KEYIN_W-1:0] key        = '0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [OCNT_W-1:0]  entry_count;
    logic               is_full_flag;
    logic               is_empty_flag;
    logic               cfg_valid  = 1'b0;
    logic               cfg_ready;
    logic [CFG_W-1:0]   cfg_limit  = CFG_LIMIT_RESET;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    bit   quiet_input = 1'b0;
    t_key key_pool [32];

    bounded_set_table dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_command            (command),
        .i_key                (key),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_status             (status),
        .o_found              (found),
        .o_entry_count        (entry_count),
        .o_is_full_flag       (is_full_flag),
        .o_is_empty_flag      (is_empty_flag),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cfg_capacity_limit (cfg_limit)
    );

    bst_checker u_checker (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_in_valid           (in_valid),
        .i_in_ready           (in_ready),
        .i_command            (command),
        .i_key                (key),
        .i_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .i_status             (status),
        .i_found              (found),
        .i_entry_count        (entry_count),
        .i_is_full_flag       (is_full_flag),
        .i_is_empty_flag      (is_empty_flag),
        .i_cfg_valid          (cfg_valid),
        .i_cfg_ready          (cfg_ready),
        .i_cfg_capacity_limit (cfg_limit),
        .o_fail_count         (fail_count),
        .o_pending            (pending)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side backpressure: short flickers, occasional long stalls, some open stretches
    initial begin
        int r;
        @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                out_ready <= 1'b1;
                repeat ($urandom_range(50, 150)) @(posedge clk);
            end else if (r < 18) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end else begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_input || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mode 0 fills the set, mode 1 drains it, mode 2 mixes
    function automatic logic [CMD_W-1:0] pick_command(int mode);
        int r;
        int add_w;
        int rem_w;
        r     = $urandom_range(0, 99);
        add_w = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
        rem_w = (mode == 0) ? 15 : (mode == 1) ? 60 : 35;
        if (r < add_w)
            return CMD_ADD;
        if (r < add_w + rem_w)
            return CMD_REMOVE;
        if (r < 97)
            return CMD_LOOKUP;
        return CMD_RESERVED;
    endfunction

    task automatic send_command(logic [CMD_W-1:0] cmd, t_key k);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        key      <= k;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_limit(logic [CFG_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent;
        int phase;
        int mode;
        int span;
        int n_items;
        int first_limits [6];
        t_key k;

        first_limits = '{16, 1, 31, 17, 0, 16};
        key_pool[0]  = '0;
        key_pool[1]  = '1;
        for (int i = 2; i < 32; i++)
            key_pool[i] = $urandom();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: runs at the limit left by reset
        send_command(CMD_LOOKUP,   32'h0000_0000);
        send_command(CMD_REMOVE,   32'h0000_0000);   // remove on empty set
        send_command(CMD_ADD,      32'h0000_0000);
        send_command(CMD_ADD,      32'hFFFF_FFFF);
        send_command(CMD_ADD,      32'h0000_0000);   // duplicate
        send_command(CMD_LOOKUP,   32'h0000_0000);
        send_command(CMD_RESERVED, 32'hFFFF_FFFF);   // unused code behaves as lookup
        send_command(CMD_REMOVE,   32'h1234_5678);   // absent key
        send_command(CMD_ADD,      32'hA5A5_A5A5);
        send_command(CMD_REMOVE,   32'h0000_0000);   // head removal, rest shifts down
        send_command(CMD_LOOKUP,   32'hFFFF_FFFF);
        send_command(CMD_ADD,      32'h5A5A_5A5A);

        // limit dropped under the current count: nothing evicted, adds refused
        write_limit(5'd2);
        send_command(CMD_ADD,      32'h0000_0001);
        send_command(CMD_LOOKUP,   32'hA5A5_A5A5);
        send_command(CMD_REMOVE,   32'hFFFF_FFFF);
        send_command(CMD_ADD,      32'hFFFF_FFFF);

        // zero limit acts as one
        write_limit(5'd0);
        send_command(CMD_REMOVE,   32'hA5A5_A5A5);
        send_command(CMD_ADD,      32'h5A5A_5A5A);   // full, key already held
        send_command(CMD_REMOVE,   32'h5A5A_5A5A);
        send_command(CMD_ADD,      32'h0000_0007);
        send_command(CMD_REMOVE,   32'h0000_0007);

        // random phases, each under its own limit
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            write_limit(phase < 6 ? CFG_W'(first_limits[phase]) : CFG_W'($urandom_range(0, 31)));
            mode        = phase % 3;
            span        = (mode == 0) ? $urandom_range(18, 32) : $urandom_range(4, 32);
            quiet_input = ($urandom_range(0, 3) == 0);
            n_items     = $urandom_range(40, 70);
            if (n_items > RANDOM_ITEMS - sent)
                n_items = RANDOM_ITEMS - sent;
            repeat (n_items) begin
                k = ($urandom_range(0, 3) == 0) ? t_key'($urandom())
                                                : key_pool[$urandom_range(0, span - 1)];
                send_command(pick_command(mode), k);
                sent++;
            end
            phase++;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/bst_pkg.sv
src/bst_mem.sv
src/bounded_set_table.sv
verif/bst_checker.sv
verif/bounded_set_table_tb.sv
